FILE: sv/sst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg: shared definitions for the small set table
// Operation codes, data widths and the control bundle that drives the cells.
// ----------------------------------------------------------------------------
package sst_pkg;

	// element width and default table size
	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 16;
	localparam int COUNT_W      = 5;

	// operation codes carried in the input tuser field
	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_DEL = 2'd1;
	localparam logic [1:0] MODE_QRY = 2'd2;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic cmp;   // latch this cell's match against the lookup value
		logic del;   // shift down at and above the matching cell
		logic add;   // first empty cell takes the lookup value
	} cell_ctl_t;

endpackage

FILE: sv/sst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_cell: one slot of the set table
// Holds one element and its occupied flag, compares it with the lookup value
// and hands a running "match seen" flag and its contents to its neighbors.
// ----------------------------------------------------------------------------
module sst_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sst_pkg::cell_ctl_t        ctl,
	input  logic [sst_pkg::DATA_W-1:0] value,
	input  logic                      prev_seen,   // match found in a lower cell
	input  logic                      prev_valid,  // lower cell is occupied
	input  logic                      next_valid,  // upper cell is occupied
	input  logic [sst_pkg::DATA_W-1:0] next_data,  // upper cell contents
	output logic                      seen,
	output logic                      valid,
	output logic [sst_pkg::DATA_W-1:0] data
);

	logic                       valid_q;
	logic                       match_q;
	logic [sst_pkg::DATA_W-1:0] data_q;
	logic                       take_up;
	logic                       take_new;

	// match chain: set from this cell upward once any cell matched
	assign seen     = prev_seen | match_q;
	assign take_up  = ctl.del & seen;
	assign take_new = ctl.add & ~valid_q & prev_valid;
	assign valid    = valid_q;
	assign data     = data_q;

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.cmp) begin
				match_q <= valid_q & (data_q == value);
			end
			if (take_up) begin
				valid_q <= next_valid;
			end else if (take_new) begin
				valid_q <= 1'b1;
			end
		end
	end

	// element storage
	always_ff @(posedge clk) begin
		if (take_up) begin
			data_q <= next_data;
		end else if (take_new) begin
			data_q <= value;
		end
	end

endmodule

FILE: sv/small_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_set_table: insertion-ordered set of up to CAPACITY 32-bit values
// Add, delete and membership query on a row of cells; every transfer in gives
// one transfer out with found flag, count after and full-drop flag.
//
//   channel | dir | payload (low bit first)
//   s_*     | in  | tdata: value[31:0]; tuser: mode[1:0]
//   m_*     | out | tdata: found, count[4:0], full_drop, pad
//
// Each operation runs in two steps: the first compares every cell with the value,
// the second resolves the match chain along the row and updates the cells.
// A new input is taken only once the previous operation commits, which waits for the output register to drain.
// Reset empties the table at once; a stalled output holds the row's update.
// ----------------------------------------------------------------------------
module small_set_table #(
	parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // found, count[4:0], full_drop, zero
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                        v1_q;
	logic                        v2_q;
	logic [1:0]                  mode_q;
	logic [sst_pkg::DATA_W-1:0]  value_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [CNT_W-1:0]            cnt_nxt;
	logic                        out_valid_q;
	logic [7:0]                  out_data_q;

	logic                        commit;
	logic                        found;
	logic                        full;
	logic                        drop;
	logic                        s_fire;
	logic [CNT_W+sst_pkg::COUNT_W-1:0] cnt_ext;
	sst_pkg::cell_ctl_t          ctl;

	// valid_c[i+1] is cell i; index 0 and CAPACITY+1 are the row ends
	logic [CAPACITY:0]           seen_c;
	logic [CAPACITY+1:0]         valid_c;
	logic [sst_pkg::DATA_W-1:0]  data_c [CAPACITY+1];

	// handshake and stage control
	assign commit   = v2_q & (~out_valid_q | m_tready);
	assign s_tready = ~v1_q & (~v2_q | commit);
	assign s_fire   = s_tvalid & s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// row ends
	assign seen_c[0]           = 1'b0;
	assign valid_c[0]          = 1'b1;
	assign valid_c[CAPACITY+1] = 1'b0;
	assign data_c[CAPACITY]    = '0;

	assign found = seen_c[CAPACITY];
	assign full  = valid_c[CAPACITY];

	// commands to the row
	always_comb begin
		ctl.cmp = v1_q;
		ctl.del = commit & (mode_q == sst_pkg::MODE_DEL) & found;
		ctl.add = commit & (mode_q == sst_pkg::MODE_ADD) & ~found & ~full;
		drop    = (mode_q == sst_pkg::MODE_ADD) & ~found & full;
		cnt_nxt = cnt_q;
		if (ctl.add) begin
			cnt_nxt = cnt_q + 1'b1;
		end else if (ctl.del) begin
			cnt_nxt = cnt_q - 1'b1;
		end
		cnt_ext = {{sst_pkg::COUNT_W{1'b0}}, cnt_nxt};
	end

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sst_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.value      (value_q),
			.prev_seen  (seen_c[i]),
			.prev_valid (valid_c[i]),
			.next_valid (valid_c[i+2]),
			.next_data  (data_c[i+1]),
			.seen       (seen_c[i+1]),
			.valid      (valid_c[i+1]),
			.data       (data_c[i])
		);
	end

	// stage flags, count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v1_q <= s_fire;
			if (v1_q) begin
				v2_q <= 1'b1;
			end else if (commit) begin
				v2_q <= 1'b0;
			end
			cnt_q <= cnt_nxt;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operation and result payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			mode_q  <= s_tuser;
			value_q <= s_tdata;
		end
		if (commit) begin
			out_data_q <= {1'b0, drop, cnt_ext[sst_pkg::COUNT_W-1:0], found};
		end
	end

endmodule
